// ===== rtl/irnb_pkg.sv =====
// Package with shared constants, types and helpers for the image resampler.
package irnb_pkg;

  localparam int MaxInWidthDef  = 256;
  localparam int MaxInHeightDef = 256;
  localparam int MaxOutSizeDef  = 4096;
  localparam int FracBitsDef    = 16;

  localparam int NumChan  = 4;
  localparam int ChanW    = 8;
  localparam int PixW     = NumChan * ChanW;
  localparam int InSizeW  = 9;
  localparam int OutSizeW = 13;
  localparam int PosW     = 12;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegInWidth   = 3'd0;
  localparam logic [2:0] RegInHeight  = 3'd1;
  localparam logic [2:0] RegOutWidth  = 3'd2;
  localparam logic [2:0] RegOutHeight = 3'd3;
  localparam logic [2:0] RegMode      = 3'd4;
  localparam logic [2:0] RegChanCount = 3'd5;

  // Status codes of a result transaction.
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatBadChan  = 2'd1;
  localparam logic [1:0] StatOutRange = 2'd2;

  localparam logic FuncLoad    = 1'b0;
  localparam logic FuncRequest = 1'b1;
  localparam logic ModeNearest = 1'b0;

  // Per-item control that rides with the pipeline.
  typedef struct packed {
    logic       valid;
    logic       nearest;
    logic [2:0] chans;
    logic [1:0] status;
  } ctl_t;

endpackage

// ===== rtl/irnb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module irnb_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/irnb_coord.sv =====
// Pipelined source coordinate unit: S = floor((2p+1)*in*2^F / (2*out)) - 2^(F-1).
// Division by the output size uses a restoring divider, one quotient bit per stage.
module irnb_coord
  import irnb_pkg::*;
#(
  parameter int MaxIn    = MaxInWidthDef,
  parameter int MaxOut   = MaxOutSizeDef,
  parameter int FracBits = FracBitsDef
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [PosW-1:0]             pos,
  input  logic [$clog2(MaxIn+1)-1:0]  in_size,
  input  logic [$clog2(MaxOut+1)-1:0] dst_size,
  output logic [$clog2(MaxIn)-1:0]    idx0,
  output logic [$clog2(MaxIn)-1:0]    idx1,
  output logic [$clog2(MaxIn)-1:0]    idx_near,
  output logic signed [FracBits+1:0]  weight
);

  localparam int InW  = $clog2(MaxIn+1);
  localparam int OutW = $clog2(MaxOut+1);
  localparam int IdxW = $clog2(MaxIn);
  localparam int NumW = PosW + 1 + InW;
  // Quotient < 2*in*2^F fits NumW+F bits is overkill; quotient <= in*2^F.
  localparam int QW   = InW + FracBits + 1;
  localparam int DivW = OutW + 1;
  localparam int Stg  = QW;

  // Stage 0: numerator product (2p+1)*in.
  logic [NumW-1:0] num_r;
  logic [DivW-1:0] den0_r;
  logic [InW-1:0]  isz0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= NumW'({pos, 1'b1}) * NumW'(in_size);
      den0_r <= {dst_size, 1'b0};
      isz0_r <= in_size;
    end
  end

  // Divider stages. Numerator bits are (num << F); quotient bits above QW are zero
  // because the quotient never exceeds in*2^F.
  localparam int NW = NumW + FracBits;
  logic [NW-1:0]   nsh_r [Stg+1];
  logic [DivW:0]   rem_r [Stg+1];
  logic [QW-1:0]   q_r   [Stg+1];
  logic [DivW-1:0] den_r [Stg+1];
  logic [InW-1:0]  isz_r [Stg+1];

  always_comb begin
    nsh_r[0] = {num_r, {FracBits{1'b0}}};
    rem_r[0] = '0;
    q_r[0]   = '0;
    den_r[0] = den0_r;
    isz_r[0] = isz0_r;
  end

  // Leading numerator bits above the quotient width are folded into the start remainder.
  for (genvar s = 0; s < Stg; s++) begin : g_div
    logic [DivW+1:0] trial;
    logic [DivW:0]   rem_in;
    logic [NW-1:0]   nsh_in;
    always_comb begin
      if (s == 0) begin
        rem_in = (DivW+1)'(nsh_r[0] >> QW);
        nsh_in = nsh_r[0] << (NW - QW);
      end else begin
        rem_in = rem_r[s];
        nsh_in = nsh_r[s];
      end
      trial = {rem_in, nsh_in[NW-1]} - {1'b0, 1'b0, den_r[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nsh_r[s+1] <= nsh_in << 1;
        den_r[s+1] <= den_r[s];
        isz_r[s+1] <= isz_r[s];
        if (!trial[DivW+1]) begin
          rem_r[s+1] <= trial[DivW:0];
          q_r[s+1]   <= {q_r[s][QW-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= {rem_in[DivW-1:0], nsh_in[NW-1]};
          q_r[s+1]   <= {q_r[s][QW-2:0], 1'b0};
        end
      end
    end
  end

  // Final stage: indexes and weight.
  logic signed [QW:0] sfix;
  logic [QW-1:0]      ip_fl, ip_nr;
  logic [IdxW-1:0]    lim, f0;
  always_comb begin
    sfix  = $signed({1'b0, q_r[Stg]}) - $signed((QW+1)'(1) <<< (FracBits-1));
    lim   = IdxW'(isz_r[Stg] - InW'(1));
    ip_fl = sfix[QW] ? '0 : (QW'(sfix) >> FracBits);
    ip_nr = q_r[Stg] >> FracBits;
    f0    = (ip_fl > QW'(lim)) ? lim : IdxW'(ip_fl);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0     <= f0;
      idx1     <= (f0 < lim) ? f0 + IdxW'(1) : lim;
      idx_near <= (sfix[QW] || ip_nr <= QW'(lim)) ? (sfix[QW] ? '0 : IdxW'(ip_nr)) : lim;
      weight   <= (FracBits+2)'(sfix - $signed({1'b0, f0, {FracBits{1'b0}}}));
    end
  end

endmodule

// ===== rtl/irnb_lane.sv =====
// One channel lane: two row blends, one column blend, rounding and saturation.
module irnb_lane
  import irnb_pkg::*;
#(
  parameter int FracBits = FracBitsDef
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ChanW-1:0]           a,
  input  logic [ChanW-1:0]           b,
  input  logic [ChanW-1:0]           d,
  input  logic [ChanW-1:0]           e,
  input  logic signed [FracBits+1:0] wx,
  input  logic signed [FracBits+1:0] wy,
  output logic [ChanW-1:0]           res
);

  localparam int RW = ChanW + FracBits + 4;
  localparam int VW = RW + FracBits + 4;

  // Stage 1: row blends.
  logic signed [RW-1:0]         r0_r, r1_r;
  logic signed [FracBits+1:0]   wy_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r0_r <= RW'($signed({1'b0, a}) <<< FracBits)
            + RW'(wx * $signed({1'b0, b} - {1'b0, a}));
      r1_r <= RW'($signed({1'b0, d}) <<< FracBits)
            + RW'(wx * $signed({1'b0, e} - {1'b0, d}));
      wy_r <= wy;
    end
  end

  // Stage 2: column blend.
  logic signed [RW:0]   dr;
  logic signed [VW-1:0] v_r;
  assign dr = RW'(r1_r) - RW'(r0_r);
  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= (VW'(r0_r) <<< FracBits) + VW'(wy_r * dr);
    end
  end

  // Stage 3: round and saturate.
  logic signed [VW-1:0] vr;
  logic [VW-1:0]        sh;
  assign vr = v_r + (VW'(1) <<< (2*FracBits-1));
  assign sh = VW'(vr) >> (2*FracBits);
  always_ff @(posedge clk) begin
    if (en) begin
      if (v_r <= 0) begin
        res <= '0;
      end else if (sh > VW'(255)) begin
        res <= 8'hff;
      end else begin
        res <= ChanW'(sh);
      end
    end
  end

endmodule

// ===== rtl/image_resize_nearest_bilinear.sv =====
// Top level of the image resampler: registers, frame store banks, lanes, output merge.
//
// The frame store is split into four banks by x and y parity, so that the four bilinear
// neighbors are read in parallel. Loads and requests share one pipeline and both are
// taken at one transaction per clock while the result side does not stall. A request
// passes a product stage, the restoring divider of the coordinate unit (one stage per
// quotient bit, 26 stages at default sizes) and an index stage, then the bank read, three
// blend stages and the output register. A load is written into its bank when it reaches
// the bank read stage, so every request sees exactly the loads accepted before it. The
// whole pipeline advances only when the output register is empty or being taken, so
// stall on the result side holds it.
module image_resize_nearest_bilinear
  import irnb_pkg::*;
#(
  parameter int MAX_IN_WIDTH  = MaxInWidthDef,
  parameter int MAX_IN_HEIGHT = MaxInHeightDef,
  parameter int MAX_OUT_SIZE  = MaxOutSizeDef,
  parameter int FRAC_BITS     = FracBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [PosW-1:0]    in_pos_x,
  input  logic [PosW-1:0]    in_pos_y,
  input  logic [ChanW-1:0]   in_chan0,
  input  logic [ChanW-1:0]   in_chan1,
  input  logic [ChanW-1:0]   in_chan2,
  input  logic [ChanW-1:0]   in_chan3,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ChanW-1:0]   out_res0,
  output logic [ChanW-1:0]   out_res1,
  output logic [ChanW-1:0]   out_res2,
  output logic [ChanW-1:0]   out_res3,
  output logic [1:0]         out_status,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int XW  = $clog2(MAX_IN_WIDTH);
  localparam int YW  = $clog2(MAX_IN_HEIGHT);
  localparam int IWW = $clog2(MAX_IN_WIDTH+1);
  localparam int IHW = $clog2(MAX_IN_HEIGHT+1);
  localparam int OW  = $clog2(MAX_OUT_SIZE+1);
  localparam int BXW = (XW > 1) ? XW-1 : 1;
  localparam int BYW = (YW > 1) ? YW-1 : 1;
  localparam int BDepth = (1 << BXW) * (1 << BYW);

  // Configuration registers.
  logic [InSizeW-1:0]  in_width_r, in_height_r;
  logic [OutSizeW-1:0] out_width_r, out_height_r;
  logic                mode_r;
  logic [2:0]          chan_cnt_r;
  logic                cfg_wr;
  logic [2:0]          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r   <= InSizeW'(256);
      in_height_r  <= InSizeW'(256);
      out_width_r  <= OutSizeW'(256);
      out_height_r <= OutSizeW'(256);
      mode_r       <= 1'b1;
      chan_cnt_r   <= 3'd3;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegInWidth:   in_width_r   <= cfg_pwdata[InSizeW-1:0];
        RegInHeight:  in_height_r  <= cfg_pwdata[InSizeW-1:0];
        RegOutWidth:  out_width_r  <= cfg_pwdata[OutSizeW-1:0];
        RegOutHeight: out_height_r <= cfg_pwdata[OutSizeW-1:0];
        RegMode:      mode_r       <= cfg_pwdata[0];
        RegChanCount: chan_cnt_r   <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Register read decoder.
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      RegInWidth:   cfg_prdata = 32'(in_width_r);
      RegInHeight:  cfg_prdata = 32'(in_height_r);
      RegOutWidth:  cfg_prdata = 32'(out_width_r);
      RegOutHeight: cfg_prdata = 32'(out_height_r);
      RegMode:      cfg_prdata = 32'(mode_r);
      RegChanCount: cfg_prdata = 32'(chan_cnt_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Effective sizes.
  logic [IWW-1:0] iw;
  logic [IHW-1:0] ih;
  logic [OW-1:0]  ow, oh;
  always_comb begin
    iw = (in_width_r == '0) ? IWW'(1) :
         (32'(in_width_r) > MAX_IN_WIDTH) ? IWW'(MAX_IN_WIDTH) : IWW'(in_width_r);
    ih = (in_height_r == '0) ? IHW'(1) :
         (32'(in_height_r) > MAX_IN_HEIGHT) ? IHW'(MAX_IN_HEIGHT) : IHW'(in_height_r);
    ow = (32'(out_width_r) > MAX_OUT_SIZE) ? OW'(MAX_OUT_SIZE) : OW'(out_width_r);
    oh = (32'(out_height_r) > MAX_OUT_SIZE) ? OW'(MAX_OUT_SIZE) : OW'(out_height_r);
  end

  // Pipeline flow: everything advances when the output register can take a value.
  logic adv, in_acc, req_acc, load_ok;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;
  assign req_acc  = in_acc && in_func == FuncRequest;
  assign load_ok  = in_acc && in_func == FuncLoad
                    && 32'(in_pos_x) < 32'(iw) && 32'(in_pos_y) < 32'(ih);

  // Entry status.
  ctl_t ctl_in;
  always_comb begin
    ctl_in.valid   = req_acc;
    ctl_in.nearest = mode_r == ModeNearest;
    ctl_in.chans   = chan_cnt_r;
    if (!(chan_cnt_r == 3'd1 || chan_cnt_r == 3'd3 || chan_cnt_r == 3'd4)) begin
      ctl_in.status = StatBadChan;
    end else if (32'(in_pos_x) >= 32'(ow) || 32'(in_pos_y) >= 32'(oh)) begin
      ctl_in.status = StatOutRange;
    end else begin
      ctl_in.status = StatOk;
    end
  end

  // Coordinate units; the out size is forced to 1 when it is zero so no divide by zero.
  logic [OW-1:0] owd, ohd;
  assign owd = (ow == '0) ? OW'(1) : ow;
  assign ohd = (oh == '0) ? OW'(1) : oh;

  logic [$clog2(MAX_IN_WIDTH)-1:0]  x0, x1, xn;
  logic [$clog2(MAX_IN_HEIGHT)-1:0] y0, y1, yn;
  logic signed [FRAC_BITS+1:0]      wx, wy;

  irnb_coord #(.MaxIn(MAX_IN_WIDTH), .MaxOut(MAX_OUT_SIZE), .FracBits(FRAC_BITS)) u_cx (
    .clk(clk), .en(adv), .pos(in_pos_x), .in_size(iw), .dst_size(owd),
    .idx0(x0), .idx1(x1), .idx_near(xn), .weight(wx)
  );
  irnb_coord #(.MaxIn(MAX_IN_HEIGHT), .MaxOut(MAX_OUT_SIZE), .FracBits(FRAC_BITS)) u_cy (
    .clk(clk), .en(adv), .pos(in_pos_y), .in_size(ih), .dst_size(ohd),
    .idx0(y0), .idx1(y1), .idx_near(yn), .weight(wy)
  );

  // Divider depths of the two units may differ; delay the shorter side to match.
  localparam int LatX = IWW + FRAC_BITS + 3;
  localparam int LatY = IHW + FRAC_BITS + 3;
  localparam int Lat  = (LatX > LatY) ? LatX : LatY;
  localparam int PadX = Lat - LatX + 1;
  localparam int PadY = Lat - LatY + 1;

  logic [XW-1:0] x0d [PadX], x1d [PadX], xnd [PadX];
  logic signed [FRAC_BITS+1:0] wxd [PadX], wyd [PadY];
  logic [YW-1:0] y0d [PadY], y1d [PadY], ynd [PadY];
  assign x0d[0] = x0; assign x1d[0] = x1; assign xnd[0] = xn; assign wxd[0] = wx;
  assign y0d[0] = y0; assign y1d[0] = y1; assign ynd[0] = yn; assign wyd[0] = wy;
  for (genvar i = 1; i < PadX; i++) begin : g_padx
    always_ff @(posedge clk) if (adv) begin
      x0d[i] <= x0d[i-1]; x1d[i] <= x1d[i-1]; xnd[i] <= xnd[i-1]; wxd[i] <= wxd[i-1];
    end
  end
  for (genvar i = 1; i < PadY; i++) begin : g_pady
    always_ff @(posedge clk) if (adv) begin
      y0d[i] <= y0d[i-1]; y1d[i] <= y1d[i-1]; ynd[i] <= ynd[i-1]; wyd[i] <= wyd[i-1];
    end
  end

  // Control delay line covering coordinate, bank read and lane stages.
  localparam int CtlLen = Lat + 1 + 3;
  ctl_t ctl_r [CtlLen];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CtlLen; i++) ctl_r[i].valid <= 1'b0;
    end else if (adv) begin
      ctl_r[0] <= ctl_in;
      for (int i = 1; i < CtlLen; i++) ctl_r[i] <= ctl_r[i-1];
    end
  end
  ctl_t ctl_a;
  assign ctl_a = ctl_r[Lat-1];

  // Neighbor positions; nearest mode reads the same pixel at all four corners.
  logic [XW-1:0] xa, xb;
  logic [YW-1:0] ya, yb;
  always_comb begin
    xa = ctl_a.nearest ? xnd[PadX-1] : x0d[PadX-1];
    xb = ctl_a.nearest ? xnd[PadX-1] : x1d[PadX-1];
    ya = ctl_a.nearest ? ynd[PadY-1] : y0d[PadY-1];
    yb = ctl_a.nearest ? ynd[PadY-1] : y1d[PadY-1];
  end

  // Load delay line: a load reaches the banks at the same stage where requests read.
  logic [PixW-1:0] wdata;
  logic [XW-1:0]   lx;
  logic [YW-1:0]   ly;
  assign wdata = {in_chan3, in_chan2, in_chan1, in_chan0};
  assign lx = XW'(in_pos_x);
  assign ly = YW'(in_pos_y);

  logic            ld_v_r [Lat];
  logic [XW-1:0]   ld_x_r [Lat];
  logic [YW-1:0]   ld_y_r [Lat];
  logic [PixW-1:0] ld_d_r [Lat];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lat; i++) ld_v_r[i] <= 1'b0;
    end else if (adv) begin
      ld_v_r[0] <= load_ok;
      for (int i = 1; i < Lat; i++) ld_v_r[i] <= ld_v_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ld_x_r[0] <= lx;
      ld_y_r[0] <= ly;
      ld_d_r[0] <= wdata;
      for (int i = 1; i < Lat; i++) begin
        ld_x_r[i] <= ld_x_r[i-1];
        ld_y_r[i] <= ld_y_r[i-1];
        ld_d_r[i] <= ld_d_r[i-1];
      end
    end
  end

  // Four banks by x and y parity; each bank is read at the neighbor of its parity.
  logic [PixW-1:0] bank_q [4];
  logic            swx_r, swy_r;
  logic            eqx_r, eqy_r;
  logic            nr_r;
  logic signed [FRAC_BITS+1:0] wx_r, wy_r;
  logic            ld_we;
  logic [XW-1:0]   ld_x;
  logic [YW-1:0]   ld_y;
  assign ld_we = adv && ld_v_r[Lat-1];
  assign ld_x  = ld_x_r[Lat-1];
  assign ld_y  = ld_y_r[Lat-1];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic           bpx, bpy;
    logic [XW-1:0]  rx;
    logic [YW-1:0]  ry;
    assign bpx = (b % 2) == 1;
    assign bpy = (b / 2) == 1;
    assign rx = (xa[0] == bpx) ? xa : xb;
    assign ry = (ya[0] == bpy) ? ya : yb;
    irnb_ram #(.Width(PixW), .Depth(BDepth)) u_ram (
      .clk(clk),
      .we(ld_we && ld_x[0] == bpx && ld_y[0] == bpy),
      .waddr({BYW'(ld_y >> 1), BXW'(ld_x >> 1)}),
      .wdata(ld_d_r[Lat-1]),
      .re(adv),
      .raddr({BYW'(ry >> 1), BXW'(rx >> 1)}),
      .rdata(bank_q[b])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      swx_r <= xa[0];
      swy_r <= ya[0];
      eqx_r <= xa == xb;
      eqy_r <= ya == yb;
      nr_r  <= ctl_a.nearest;
      wx_r  <= wxd[PadX-1];
      wy_r  <= wyd[PadY-1];
    end
  end

  // Pick the corners from the banks by parity of the base position.
  // A clamped neighbor equals the base position and comes from the base bank.
  logic            ox, oy;
  logic [PixW-1:0] p00, p10, p01, p11;
  always_comb begin
    ox  = eqx_r ? swx_r : ~swx_r;
    oy  = eqy_r ? swy_r : ~swy_r;
    p00 = bank_q[{swy_r, swx_r}];
    p10 = bank_q[{swy_r, ox}];
    p01 = bank_q[{oy, swx_r}];
    p11 = bank_q[{oy, ox}];
    if (nr_r) begin
      p10 = p00; p01 = p00; p11 = p00;
    end
  end

  // Channel lanes; nearest mode uses zero weights so the blend returns the pixel.
  logic signed [FRAC_BITS+1:0] lwx, lwy;
  assign lwx = nr_r ? '0 : wx_r;
  assign lwy = nr_r ? '0 : wy_r;
  logic [ChanW-1:0] lres [NumChan];
  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    irnb_lane #(.FracBits(FRAC_BITS)) u_lane (
      .clk(clk), .en(adv),
      .a(p00[c*ChanW +: ChanW]), .b(p10[c*ChanW +: ChanW]),
      .d(p01[c*ChanW +: ChanW]), .e(p11[c*ChanW +: ChanW]),
      .wx(lwx), .wy(lwy), .res(lres[c])
    );
  end

  // Merge stage: status, channel masking and the output register.
  ctl_t ctl_o;
  assign ctl_o = ctl_r[CtlLen-1];
  logic [ChanW-1:0] res_r [NumChan];
  logic [1:0]       status_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_o.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= ctl_o.status;
      for (int c = 0; c < NumChan; c++) begin
        res_r[c] <= (ctl_o.status == StatOk && 3'(c) < ctl_o.chans) ? lres[c] : '0;
      end
    end
  end
  assign out_res0   = res_r[0];
  assign out_res1   = res_r[1];
  assign out_res2   = res_r[2];
  assign out_res3   = res_r[3];
  assign out_status = status_r;

  // Assertions.
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("illegal status");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != StatOk |-> out_res0 == '0 && out_res3 == '0)
    else $error("error result with data");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res0) && $stable(out_status))
    else $error("result changed under stall");
  a_accept_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("input stalled with empty output register");

endmodule

// ===== bench/irnb_checker.sv =====
// Checker for the image resampler: watches both channels and the register port, predicts, compares.
module irnb_checker
  import irnb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_func,
  input  logic [PosW-1:0]  in_pos_x,
  input  logic [PosW-1:0]  in_pos_y,
  input  logic [ChanW-1:0] in_chan0,
  input  logic [ChanW-1:0] in_chan1,
  input  logic [ChanW-1:0] in_chan2,
  input  logic [ChanW-1:0] in_chan3,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [ChanW-1:0] out_res0,
  input  logic [ChanW-1:0] out_res1,
  input  logic [ChanW-1:0] out_res2,
  input  logic [ChanW-1:0] out_res3,
  input  logic [1:0]       out_status,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [4:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  input  logic             cfg_pready,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StoreW   = 256;
  localparam longint One  = 64'sd1 << FracBitsDef;
  localparam longint Half = 64'sd1 << (FracBitsDef - 1);

  typedef struct packed {
    logic [3:0][ChanW-1:0] res;
    logic [1:0]            status;
  } pixel_t;

  logic [PixW-1:0]     frame [StoreW*StoreW];
  logic [InSizeW-1:0]  cur_in_w, cur_in_h;
  logic [OutSizeW-1:0] cur_out_w, cur_out_h;
  logic                cur_mode;
  logic [2:0]          cur_chans;
  pixel_t              pixel_q[$];

  function automatic int clamp_in(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // Pixel-center mapping, floored to the fraction bits.
  function automatic longint src_pos(int p, int isz, int osz);
    longint num;
    num = (longint'(2 * p + 1) * longint'(isz)) << FracBitsDef;
    return num / (2 * longint'(osz)) - Half;
  endfunction

  function automatic int pick_index(longint s, int isz, bit round_it);
    longint i;
    if (s < 0) return 0;
    i = round_it ? ((s + Half) >>> FracBitsDef) : (s >>> FracBitsDef);
    return (i > isz - 1) ? isz - 1 : int'(i);
  endfunction

  function automatic longint chan_at(int x, int y, int c);
    return longint'((frame[y * StoreW + x] >> (8 * c)) & 32'hFF);
  endfunction

  function automatic pixel_t resample(int px, int py);
    pixel_t r;
    int iw, ih, ow, oh, x0, y0, x1, y1;
    longint sx, sy, wx, wy, a, b, d, e, r0, r1, v, q;
    r = '0;
    iw = clamp_in(int'(cur_in_w), MaxInWidthDef);
    ih = clamp_in(int'(cur_in_h), MaxInHeightDef);
    ow = (int'(cur_out_w) > MaxOutSizeDef) ? MaxOutSizeDef : int'(cur_out_w);
    oh = (int'(cur_out_h) > MaxOutSizeDef) ? MaxOutSizeDef : int'(cur_out_h);
    if (!(cur_chans inside {3'd1, 3'd3, 3'd4})) begin
      r.status = StatBadChan;
      return r;
    end
    if (px >= ow || py >= oh) begin
      r.status = StatOutRange;
      return r;
    end
    r.status = StatOk;
    sx = src_pos(px, iw, ow);
    sy = src_pos(py, ih, oh);
    if (cur_mode == ModeNearest) begin
      x0 = pick_index(sx, iw, 1'b1);
      y0 = pick_index(sy, ih, 1'b1);
      for (int c = 0; c < cur_chans; c++) r.res[c] = ChanW'(chan_at(x0, y0, c));
    end else begin
      x0 = pick_index(sx, iw, 1'b0);
      y0 = pick_index(sy, ih, 1'b0);
      x1 = (x0 + 1 < iw) ? x0 + 1 : iw - 1;
      y1 = (y0 + 1 < ih) ? y0 + 1 : ih - 1;
      wx = sx - longint'(x0) * One;
      wy = sy - longint'(y0) * One;
      for (int c = 0; c < cur_chans; c++) begin
        a  = chan_at(x0, y0, c);
        b  = chan_at(x1, y0, c);
        d  = chan_at(x0, y1, c);
        e  = chan_at(x1, y1, c);
        r0 = a * One + wx * (b - a);
        r1 = d * One + wx * (e - d);
        v  = r0 * One + wy * (r1 - r0);
        if (v <= 0) begin
          q = 0;
        end else begin
          q = (v + (64'sd1 <<< (2 * FracBitsDef - 1))) >>> (2 * FracBitsDef);
          if (q > 255) q = 255;
        end
        r.res[c] = q[7:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_t got, want;
    int iw, ih;
    if (!rst_n) begin
      cur_in_w   = 9'd256;
      cur_in_h   = 9'd256;
      cur_out_w  = 13'd256;
      cur_out_h  = 13'd256;
      cur_mode   = 1'b1;
      cur_chans  = 3'd3;
      fail_count = 0;
      pixel_q.delete();
    end else begin
      // Register writes take effect for every later transaction.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          RegInWidth:   cur_in_w  = cfg_pwdata[InSizeW-1:0];
          RegInHeight:  cur_in_h  = cfg_pwdata[InSizeW-1:0];
          RegOutWidth:  cur_out_w = cfg_pwdata[OutSizeW-1:0];
          RegOutHeight: cur_out_h = cfg_pwdata[OutSizeW-1:0];
          RegMode:      cur_mode  = cfg_pwdata[0];
          RegChanCount: cur_chans = cfg_pwdata[2:0];
          default: ;
        endcase
      end
      // Result transaction against the oldest predicted pixel.
      if (out_valid && !out_stall) begin
        got.res    = {out_res3, out_res2, out_res1, out_res0};
        got.status = out_status;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d res %h", $time,
                   got.status, got.res);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count++;
          end
          for (int c = 0; c < NumChan; c++) begin
            if (got.res[c] !== want.res[c]) begin
              $display("%0t: res%0d expected %0d actual %0d", $time, c,
                       want.res[c], got.res[c]);
              fail_count++;
            end
          end
        end
      end
      // Input transaction: a load updates the store, a request is predicted.
      if (in_valid && !in_stall) begin
        iw = clamp_in(int'(cur_in_w), MaxInWidthDef);
        ih = clamp_in(int'(cur_in_h), MaxInHeightDef);
        if (in_func == FuncLoad) begin
          if (int'(in_pos_x) < iw && int'(in_pos_y) < ih)
            frame[int'(in_pos_y) * StoreW + int'(in_pos_x)] =
              {in_chan3, in_chan2, in_chan1, in_chan0};
        end else begin
          pixel_q.push_back(resample(int'(in_pos_x), int'(in_pos_y)));
        end
      end
    end
    pending <= pixel_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the image resampler: clock, reset, stimulus, idling and the verdict.
module tb;
  import irnb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;
  localparam int DrainWait = 100;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_func = 1'b0;
  logic [PosW-1:0]  in_pos_x = '0;
  logic [PosW-1:0]  in_pos_y = '0;
  logic [ChanW-1:0] in_chan0 = '0, in_chan1 = '0, in_chan2 = '0, in_chan3 = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ChanW-1:0] out_res0, out_res1, out_res2, out_res3;
  logic [1:0]       out_status;
  logic             cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]       cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;
  int               fail_count, pending;

  bit quiet = 1'b0;
  int hold_token = 0;
  int idle_cycles = 0;

  image_resize_nearest_bilinear dut (.*);

  irnb_checker u_checker (.*);

  always #5 clk = ~clk;

  // Receiver side: random stall bursts, plus one long hold-off on request.
  always @(posedge clk) begin
    static int burst = 0, run = 0, hold = 0, seen = 0;
    if (hold_token != seen) begin
      seen = hold_token;
      hold = 400;
    end
    if (hold > 0) begin
      hold--;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (burst > 0) begin
      burst--;
      out_stall <= 1'b1;
    end else if (run > 0) begin
      run--;
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        run = $urandom_range(0, 30);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // One input transaction, with an optional random gap in front.
  task automatic send(logic func, int x, int y, logic [PixW-1:0] data);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_pos_x <= PosW'(x);
    in_pos_y <= PosW'(y);
    {in_chan3, in_chan2, in_chan1, in_chan0} <= data;
    do @(posedge clk); while (in_stall);
  endtask

  // Let all predicted results come back, then let trailing loads settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Configure, load the whole effective image, then mixed requests and loads.
  task automatic run_phase(int iw, int ih, int ow, int oh, bit mode, int chans,
                           int n_items, bit extremes, bit long_hold);
    int eiw, eih, eow, eoh, x, y;
    logic [PixW-1:0] data;
    eiw = (iw == 0) ? 1 : (iw > MaxInWidthDef ? MaxInWidthDef : iw);
    eih = (ih == 0) ? 1 : (ih > MaxInHeightDef ? MaxInHeightDef : ih);
    eow = (ow > MaxOutSizeDef) ? MaxOutSizeDef : ow;
    eoh = (oh > MaxOutSizeDef) ? MaxOutSizeDef : oh;
    reg_write(RegInWidth, iw);
    reg_write(RegInHeight, ih);
    reg_write(RegOutWidth, ow);
    reg_write(RegOutHeight, oh);
    reg_write(RegMode, mode);
    reg_write(RegChanCount, chans);
    for (int j = 0; j < eih; j++) begin
      for (int i = 0; i < eiw; i++) begin
        if (extremes) data = ((i + j) % 2) ? '1 : '0;
        else data = $urandom;
        send(FuncLoad, i, j, data);
      end
    end
    if (long_hold) hold_token++;
    for (int k = 0; k < n_items; k++) begin
      data = $urandom;
      case ($urandom_range(0, 19))
        0: send(FuncLoad, $urandom_range(0, eiw - 1), $urandom_range(0, eih - 1), data);
        1: send(FuncLoad, $urandom_range(0, 4095), $urandom_range(0, 4095), data);
        2: send(FuncRequest, $urandom_range(0, 4095), $urandom_range(0, 4095), data);
        3: begin
          // Corners and just past the output edges.
          x = $urandom_range(0, 1) ? 0 : eow - 1 + $urandom_range(0, 1);
          y = $urandom_range(0, 1) ? 0 : eoh - 1 + $urandom_range(0, 1);
          send(FuncRequest, (x < 0) ? 0 : x, (y < 0) ? 0 : y, data);
        end
        default: begin
          x = (eow > 0) ? $urandom_range(0, (eow > 4096 ? 4096 : eow) - 1) : 0;
          y = (eoh > 0) ? $urandom_range(0, (eoh > 4096 ? 4096 : eoh) - 1) : 0;
          send(FuncRequest, x, y, data);
        end
      endcase
    end
    drain();
  endtask

  initial begin
    int iw, ih, ow, oh, chans;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size extremes, clamped sizes, both modes, bad channel counts.
    run_phase(256, 1, 4096, 1, 1'b0, 4, 4, 1'b1, 1'b0);
    run_phase(300, 1, 8191, 2, 1'b1, 4, 4, 1'b1, 1'b0);
    run_phase(1, 256, 1, 4096, 1'b1, 1, 3, 1'b1, 1'b0);
    run_phase(0, 0, 0, 5, 1'b0, 3, 2, 1'b0, 1'b0);
    run_phase(2, 2, 9, 9, 1'b1, 2, 2, 1'b1, 1'b0);
    run_phase(2, 3, 7, 1, 1'b1, 0, 2, 1'b0, 1'b0);
    run_phase(3, 2, 1, 1, 1'b1, 7, 2, 1'b0, 1'b0);
    run_phase(3, 3, 11, 11, 1'b1, 3, 3, 1'b1, 1'b0);

    // Random settings, mostly small images and outputs.
    for (int p = 0; p < 8; p++) begin
      if (p >= 6) quiet = 1'b1;
      iw = $urandom_range(1, 12);
      ih = $urandom_range(1, 12);
      ow = $urandom_range(1, 40);
      oh = $urandom_range(1, 40);
      case ($urandom_range(0, 7))
        0: begin iw = $urandom_range(0, 511); ih = $urandom_range(0, 2); end
        1: begin ow = $urandom_range(0, 8191); oh = $urandom_range(0, 8191); end
        2: begin iw = 0; ow = $urandom_range(1, 3); end
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0: chans = $urandom_range(0, 7);
        1, 2, 3: chans = 1;
        4, 5, 6: chans = 3;
        default: chans = 4;
      endcase
      run_phase(iw, ih, ow, oh, $urandom_range(0, 1), chans, 70, $urandom_range(0, 5) == 0,
                p == 3);
    end

    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
